>>> rtl/rsp_pkg.sv
// shared types, constants and gf(256) helpers for the reed-solomon parity encoder
package rsp_pkg;

  // low byte of the field polynomial 0x11d
  localparam logic [7:0] GF_REDUCE = 8'd29;
  localparam logic [7:0] GF_MASK   = 8'd255;
  // parity count limits and reset value
  localparam int EC_MIN   = 2;
  localparam int EC_RESET = 10;
  localparam int CFG_W    = 5;

  // generator sequencer states
  typedef enum logic [1:0] {
    GEN_IDLE  = 2'b01,
    GEN_BUILD = 2'b10
  } rsp_gen_state_t;

  // generator status toward the front end
  typedef struct packed {
    logic busy;   // generator being rebuilt
    logic clear;  // register write, drop the block in progress
  } rsp_gen_stat_t;

  // multiply by alpha
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if (a[7]) begin
      r = r ^ GF_REDUCE;
    end
    return r & GF_MASK;
  endfunction

  // shift-and-add gf(256) product
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] p;
    x = a;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        p = p ^ x;
      end
      x = gf_xtime(x);
    end
    return p;
  endfunction

endpackage

>>> rtl/rsp_intf.sv
// channel interfaces: message bytes in, parity bytes out
interface rsp_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsp_par_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

>>> rtl/rsp_gen.sv
// generator polynomial sequencer: one (x + alpha^i) factor per cycle
module rsp_gen import rsp_pkg::*; #(
  parameter int MAX_EC = 30,
  parameter int EW     = $clog2(MAX_EC + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic [EW-1:0]            ec,
  output logic [MAX_EC-1:0][7:0]   gen,
  output rsp_gen_stat_t            stat
);

  rsp_gen_state_t             state;
  logic [7:0]                 root;
  logic [EW-1:0]              iter;
  logic [EW-1:0]              ec_wr;
  logic [MAX_EC-1:0][7:0]     gen_next;

  // saturate the written count into the legal range
  always_comb begin
    priority if (int'(cfg_data) < EC_MIN) begin
      ec_wr = EW'(EC_MIN);
    end else if (int'(cfg_data) > MAX_EC) begin
      ec_wr = EW'(MAX_EC);
    end else begin
      ec_wr = EW'(cfg_data);
    end
  end

  // multiply current polynomial by (x + root), all coefficients at once
  always_comb begin
    for (int k = 0; k < MAX_EC; k++) begin
      if (k == 0) begin
        gen_next[k] = gen[k] ^ root;
      end else begin
        gen_next[k] = gen[k] ^ gf_mul(gen[k-1], root);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_BUILD;
      ec    <= (EC_RESET > MAX_EC) ? EW'(MAX_EC) : EW'(EC_RESET);
      gen   <= '0;
      root  <= 8'd1;
      iter  <= '0;
    end else if (cfg_we) begin
      state <= GEN_BUILD;
      ec    <= ec_wr;
      gen   <= '0;
      root  <= 8'd1;
      iter  <= '0;
    end else begin
      unique case (state)
        GEN_IDLE: begin
        end
        GEN_BUILD: begin
          gen  <= gen_next;
          root <= gf_xtime(root);
          iter <= iter + EW'(1);
          if (iter == ec - EW'(1)) begin
            state <= GEN_IDLE;
          end
        end
        default: state <= GEN_IDLE;
      endcase
    end
  end

  assign stat.busy  = (state != GEN_IDLE);
  assign stat.clear = cfg_we;

endmodule

>>> rtl/rsp_front.sv
// front end: takes message bytes and runs the remainder lfsr
module rsp_front import rsp_pkg::*; #(
  parameter int MAX_EC = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  rsp_msg_if.sink                  msg,
  input  logic [MAX_EC-1:0][7:0]   gen,
  input  rsp_gen_stat_t            stat,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [MAX_EC-1:0][7:0]   q_wdata
);

  logic [MAX_EC-1:0][7:0] rem;
  logic [MAX_EC-1:0][7:0] rem_next;
  logic [7:0]             fb;
  logic                   take;

  assign msg.ready = !stat.busy && !q_full;
  assign take      = msg.valid && msg.ready;

  // one division step; taps above the current degree stay zero
  always_comb begin
    fb = msg.data_byte ^ rem[0];
    for (int i = 0; i < MAX_EC; i++) begin
      if (i + 1 < MAX_EC) begin
        rem_next[i] = rem[i+1] ^ gf_mul(fb, gen[i]);
      end else begin
        rem_next[i] = gf_mul(fb, gen[i]);
      end
    end
  end

  // remainder register
  always_ff @(posedge clk) begin
    if (rst || stat.clear) begin
      rem <= '0;
    end else if (take) begin
      rem <= msg.last_byte ? '0 : rem_next;
    end
  end

  // finished remainder goes to the queue
  assign q_push  = take && msg.last_byte;
  assign q_wdata = rem_next;

endmodule

>>> rtl/rsp_fifo.sv
// two-entry queue of finished remainders
module rsp_fifo #(
  parameter int WIDTH = 240
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/rsp_back.sv
// back end: shifts one remainder out as parity bytes
module rsp_back import rsp_pkg::*; #(
  parameter int MAX_EC = 30,
  parameter int EW     = $clog2(MAX_EC + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [EW-1:0]            ec,
  input  logic                     q_empty,
  input  logic [MAX_EC-1:0][7:0]   q_rdata,
  output logic                     q_pop,
  rsp_par_if.source                par
);

  logic [MAX_EC-1:0][7:0] sh;
  logic [EW-1:0]          cnt;
  logic                   busy;
  logic                   fire;
  logic                   at_last;

  assign fire    = par.valid && par.ready;
  assign at_last = (cnt == EW'(1));
  // reload as soon as the previous block's final byte transfers
  assign q_pop   = !q_empty && (!busy || (fire && at_last));

  // serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= ec;
    end else if (fire) begin
      cnt <= cnt - EW'(1);
      if (at_last) begin
        busy <= 1'b0;
      end
    end
  end

  // parity byte shifter, highest degree in slot zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh <= q_rdata;
    end else if (fire) begin
      for (int i = 0; i < MAX_EC; i++) begin
        sh[i] <= (i + 1 < MAX_EC) ? sh[(i + 1) % MAX_EC] : 8'd0;
      end
    end
  end

  assign par.valid       = busy;
  assign par.parity_byte = sh[0];
  assign par.last_parity = at_last;

endmodule

>>> rtl/reed_solomon_parity_encoder_top.sv
// top level of the qr-style reed-solomon parity encoder
// Message bytes enter on msg at one per cycle; every byte updates all remainder taps at
// once. The byte flagged last_byte hands the remainder to a two-block queue, and the
// output side sends ec_count parity bytes on par, one per cycle while par.ready is high,
// highest degree first, with last_parity on the final one, while the next block already
// streams in. Outside generator rebuilds, the input stalls only when both queue slots hold
// blocks waiting behind the one being sent, which happens when blocks are shorter than
// ec_count bytes or when par.ready holds the output back. After reset (ec_count is then 10)
// and after every cfg_we write, msg.ready stays low while the generator is rebuilt one
// factor per cycle; a write drops any block in progress. Written counts saturate to 2..MAX_EC.
module reed_solomon_parity_encoder_top import rsp_pkg::*; #(
  parameter int MAX_EC = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  rsp_msg_if.sink          msg,
  rsp_par_if.source        par
);

  localparam int EW = $clog2(MAX_EC + 1);

  logic [EW-1:0]          ec;
  logic [MAX_EC-1:0][7:0] gen;
  rsp_gen_stat_t          gen_stat;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  logic [MAX_EC-1:0][7:0] q_wdata;
  logic [MAX_EC-1:0][7:0] q_rdata;

  rsp_gen #(.MAX_EC(MAX_EC), .EW(EW)) u_gen (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ec       (ec),
    .gen      (gen),
    .stat     (gen_stat)
  );

  rsp_front #(.MAX_EC(MAX_EC)) u_front (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .gen     (gen),
    .stat    (gen_stat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  rsp_fifo #(.WIDTH(MAX_EC * 8)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rsp_back #(.MAX_EC(MAX_EC), .EW(EW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .ec      (ec),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .par     (par)
  );

  // no message transfer while the generator is rebuilt
  a_no_take_while_build: assert property (@(posedge clk) disable iff (rst)
    gen_stat.busy |-> !msg.ready)
    else $error("message transfer during generator build");

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("remainder queue overflow");

  // a register write always starts a rebuild
  a_write_rebuilds: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> gen_stat.busy)
    else $error("register write did not start generator build");

  // a pending block reaches the output without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && !par.valid) |=> par.valid)
    else $error("queued block not loaded into serializer");

endmodule
